// ===== hdl/qbbs_pkg.sv =====
// Shared constants and types for the quantizer bin binary search block.
package qbbs_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int LEN_W       = 8;
    localparam int BIN_W       = 7;
    localparam int THR_W       = 32;
    localparam int CNT_W       = (LEN_W > IDX_W) ? LEN_W + 1 : IDX_W + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(85);

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHK0  = 5'b00010,
        ST_CHKHI = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

// ===== hdl/quantizer_bin_binary_search_core.sv =====
// Threshold table with an iterative binary search that maps a pitch to a bin index.
// A write beat is written into the table on the accepting edge and gives no result. A search
// beat runs ST_CHK0, then ST_CHKHI and ST_STEP as needed, and raises m_valid from ST_DONE.
// Throughput: one write per cycle while the sequencer is idle; a new search beat is taken only
// once the last one has left ST_DONE. The search is paced by the single registered table read
// port that the loop visits once per step; a stalled result holds the sequencer in ST_DONE.
// Reset: aresetn is synchronous, active low; it idles the sequencer, drops m_valid
// and sets table_length to 85. The threshold table is not cleared.
module quantizer_bin_binary_search_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [qbbs_pkg::IDX_W-1:0]       s_entry_index,
    input  logic signed [qbbs_pkg::THR_W-1:0] s_entry_threshold,
    input  logic signed [qbbs_pkg::THR_W-1:0] s_pitch_value,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [qbbs_pkg::BIN_W-1:0]       m_bin_index,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qbbs_pkg::LEN_W-1:0]       cfg_table_length
);

    localparam int IDX_W = qbbs_pkg::IDX_W;
    localparam int CNT_W = qbbs_pkg::CNT_W;

    // upward-rounded midpoint of a search window
    function automatic logic [IDX_W-1:0] midpoint(input logic [IDX_W-1:0] lo,
                                                  input logic [IDX_W-1:0] hi);
        logic [IDX_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} + (IDX_W+1)'(1);
        return sum[IDX_W:1];
    endfunction

    // threshold table, one write and one registered read port
    logic signed [qbbs_pkg::THR_W-1:0] mem [qbbs_pkg::MAX_ENTRIES];

    qbbs_pkg::state_t                  state_reg, state_next;
    logic [qbbs_pkg::LEN_W-1:0]        len_reg;
    logic signed [qbbs_pkg::THR_W-1:0] pitch_reg;
    logic [IDX_W-1:0]                  lo_reg, lo_next;
    logic [IDX_W-1:0]                  hi_reg, hi_next;
    logic [IDX_W-1:0]                  mid_reg;
    logic signed [qbbs_pkg::THR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]                  rd_addr;
    logic                              m_valid_reg, m_valid_next;
    logic [qbbs_pkg::BIN_W-1:0]        m_bin_reg, m_bin_next;

    logic                              in_beat;
    logic                              ge;
    logic [IDX_W-1:0]                  step_lo, step_hi;
    logic [CNT_W-1:0]                  len_ext, len_used;
    logic [IDX_W-1:0]                  last_idx;

    assign s_ready     = (state_reg == qbbs_pkg::ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_bin_reg;
    assign in_beat     = s_valid && s_ready;

    // clamp the length register to 1..MAX_ENTRIES, then take the last index
    always_comb begin
        len_ext  = CNT_W'(len_reg);
        len_used = len_ext;
        if (len_ext == '0) begin
            len_used = CNT_W'(1);
        end
        if (len_ext > CNT_W'(qbbs_pkg::MAX_ENTRIES)) begin
            len_used = CNT_W'(qbbs_pkg::MAX_ENTRIES);
        end
        last_idx = IDX_W'(len_used - CNT_W'(1));
    end

    // the one comparator shared by every step of the search
    assign ge = (pitch_reg >= rd_data_reg);

    // window after one step: advance lo to mid or pull hi below mid
    assign step_lo = ge ? mid_reg : lo_reg;
    assign step_hi = ge ? hi_reg  : mid_reg - IDX_W'(1);

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        rd_addr      = '0;
        m_valid_next = m_valid_reg;
        m_bin_next   = m_bin_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            qbbs_pkg::ST_IDLE: begin
                // entry 0 is read on the accepting edge
                rd_addr = '0;
                if (in_beat && (s_opcode == qbbs_pkg::OP_SEARCH)) begin
                    lo_next    = '0;
                    hi_next    = last_idx;
                    state_next = qbbs_pkg::ST_CHK0;
                end
            end
            qbbs_pkg::ST_CHK0: begin
                // below entry 0: bin 0; otherwise fetch the last used entry
                rd_addr = hi_reg;
                if (!ge) begin
                    state_next = qbbs_pkg::ST_DONE;
                end else begin
                    state_next = qbbs_pkg::ST_CHKHI;
                end
            end
            qbbs_pkg::ST_CHKHI: begin
                rd_addr = midpoint(lo_reg, hi_reg);
                if (ge) begin
                    lo_next    = hi_reg;
                    state_next = qbbs_pkg::ST_DONE;
                end else if (hi_reg == lo_reg) begin
                    state_next = qbbs_pkg::ST_DONE;
                end else begin
                    state_next = qbbs_pkg::ST_STEP;
                end
            end
            qbbs_pkg::ST_STEP: begin
                lo_next = step_lo;
                hi_next = step_hi;
                rd_addr = midpoint(step_lo, step_hi);
                if (step_lo == step_hi) begin
                    state_next = qbbs_pkg::ST_DONE;
                end
            end
            qbbs_pkg::ST_DONE: begin
                // hold the answer until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_bin_next   = qbbs_pkg::BIN_W'(lo_reg);
                    state_next   = qbbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qbbs_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qbbs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            len_reg     <= qbbs_pkg::LEN_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                len_reg <= cfg_table_length;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        m_bin_reg <= m_bin_next;
        if (in_beat) begin
            pitch_reg <= s_pitch_value;
        end
    end

    // table write and registered read; mid_reg tracks the address just read
    always_ff @(posedge aclk) begin
        if (in_beat && (s_opcode == qbbs_pkg::OP_WRITE)) begin
            mem[s_entry_index] <= s_entry_threshold;
        end
        rd_data_reg <= mem[rd_addr];
        mid_reg     <= rd_addr;
    end

    // the search window stays open while stepping
    a_window_open: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == qbbs_pkg::ST_STEP |-> lo_reg < hi_reg)
        else $error("search window closed while stepping");

    // the probed midpoint lies inside the window
    a_mid_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == qbbs_pkg::ST_STEP |-> (mid_reg > lo_reg) && (mid_reg <= hi_reg))
        else $error("midpoint outside the search window");

    // a new result only follows the finishing step
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == qbbs_pkg::ST_DONE)
        else $error("result raised outside the finishing step");

    // no input beat is taken while a search is in flight
    a_no_beat_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != qbbs_pkg::ST_IDLE) |=> !$past(in_beat))
        else $error("input beat accepted during a search");

endmodule

// ===== bench/quantizer_bin_binary_search_core_tb.sv =====
// Self-checking bench for the threshold table and its bin search.
module quantizer_bin_binary_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_MIN       = -64'sd2147483648;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SETTLE      = 16;

    typedef struct {
        qbbs_pkg::opcode_t                  op;
        logic [qbbs_pkg::IDX_W-1:0]         idx;
        logic signed [qbbs_pkg::THR_W-1:0]  thr;
        logic signed [qbbs_pkg::THR_W-1:0]  pitch;
    } beat_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_opcode = 1'b0;
    logic [qbbs_pkg::IDX_W-1:0]         s_entry_index = '0;
    logic signed [qbbs_pkg::THR_W-1:0]  s_entry_threshold = '0;
    logic signed [qbbs_pkg::THR_W-1:0]  s_pitch_value = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [qbbs_pkg::BIN_W-1:0]         m_bin_index;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [qbbs_pkg::LEN_W-1:0]         cfg_table_length = '0;

    // Beats waiting to go out, the beat on the bus, and the bins still owed.
    beat_t                              beats_to_send [$];
    beat_t                              beat_on_bus;
    logic [qbbs_pkg::BIN_W-1:0]         bins_due [$];

    // Shadow of the block's table and length, advanced only on accepted beats.
    logic signed [qbbs_pkg::THR_W-1:0]  thr_shadow [qbbs_pkg::MAX_ENTRIES];
    logic [qbbs_pkg::LEN_W-1:0]         len_shadow = qbbs_pkg::LEN_RESET;
    // Table as the stimulus plan sees it, used to aim pitches at thresholds.
    logic signed [qbbs_pkg::THR_W-1:0]  thr_planned [qbbs_pkg::MAX_ENTRIES];

    // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both lighter.
    int                                 idle_mode = 0;
    int                                 mismatches = 0;
    int                                 cycles = 0;

    quantizer_bin_binary_search_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_entry_index     (s_entry_index),
        .s_entry_threshold (s_entry_threshold),
        .s_pitch_value     (s_pitch_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bin_index       (m_bin_index),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_table_length  (cfg_table_length)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Clamp a programmed length to the entries the search actually spans.
    function automatic int used_entries(input int len);
        if (len == 0) return 1;
        if (len > qbbs_pkg::MAX_ENTRIES) return qbbs_pkg::MAX_ENTRIES;
        return len;
    endfunction

    // Floor search: largest index whose threshold is not above the pitch,
    // midpoint rounded up, with the below-first and at-or-above-last shortcuts.
    function automatic logic [qbbs_pkg::BIN_W-1:0] bin_of_pitch(
        input logic signed [qbbs_pkg::THR_W-1:0] pitch);
        int lo, hi, mid;
        lo = 0;
        hi = used_entries(len_shadow) - 1;
        if (pitch < thr_shadow[0]) return '0;
        if (pitch >= thr_shadow[hi]) return qbbs_pkg::BIN_W'(hi);
        while (hi != lo) begin
            mid = (lo + hi + 1) >> 1;
            if (pitch >= thr_shadow[mid]) lo = mid;
            else hi = mid - 1;
        end
        return qbbs_pkg::BIN_W'(lo);
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int send_gap_pct();
        return (idle_mode == 1) ? 57 : (idle_mode == 3) ? 25 : 0;
    endfunction

    function automatic int stall_pct();
        return (idle_mode == 2) ? 57 : (idle_mode == 3) ? 25 : 0;
    endfunction

    // Driver: hold the beat until accepted, then advance or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                // Apply the accepted beat to the shadow; searches owe one bin.
                if (beat_on_bus.op == qbbs_pkg::OP_WRITE)
                    thr_shadow[beat_on_bus.idx] = beat_on_bus.thr;
                else
                    bins_due.push_back(bin_of_pitch(beat_on_bus.pitch));
            end
            if (!s_valid || s_ready) begin
                if (beats_to_send.size() != 0 && !roll(send_gap_pct())) begin
                    beat_on_bus = beats_to_send.pop_front();
                    s_valid           <= 1'b1;
                    s_opcode          <= beat_on_bus.op;
                    s_entry_index     <= beat_on_bus.idx;
                    s_entry_threshold <= beat_on_bus.thr;
                    s_pitch_value     <= beat_on_bus.pitch;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest bin owed.
    always @(posedge aclk) begin
        logic [qbbs_pkg::BIN_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bins_due.size() == 0) begin
                    $display("%0t: bin_index %0d arrived with no search pending",
                             $time, m_bin_index);
                    mismatches++;
                end else begin
                    want = bins_due.pop_front();
                    if (m_bin_index !== want) begin
                        $display("%0t: bin_index expected %0d, got %0d",
                                 $time, want, m_bin_index);
                        mismatches++;
                    end
                end
            end
            m_ready <= !roll(stall_pct());
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_write(input int idx, input longint thr);
        beat_t b;
        b.op    = qbbs_pkg::OP_WRITE;
        b.idx   = qbbs_pkg::IDX_W'(idx);
        b.thr   = qbbs_pkg::THR_W'(thr);
        b.pitch = $urandom;
        beats_to_send.push_back(b);
        thr_planned[idx] = qbbs_pkg::THR_W'(thr);
    endtask

    task automatic push_search(input longint pitch);
        beat_t b;
        b.op    = qbbs_pkg::OP_SEARCH;
        b.idx   = qbbs_pkg::IDX_W'($urandom);
        b.thr   = $urandom;
        b.pitch = qbbs_pkg::THR_W'(pitch);
        beats_to_send.push_back(b);
    endtask

    // Load the used part of the table: mostly ascending with random steps,
    // sometimes fully scrambled to exercise the search on an unordered table.
    task automatic load_table(input int cnt, input bit ascending);
        longint v, span, step_max;
        int i;
        span = 64'd4294967295 / (cnt + 1);
        case ($urandom_range(0, 3))
            0:       step_max = (span < 2) ? span : 2;
            1:       step_max = (span < 70000) ? span : 70000;
            default: step_max = span;
        endcase
        v = Q_MIN + $urandom_range(0, 32'(span));
        for (i = 0; i < cnt; i++) begin
            if (ascending) begin
                push_write(i, v);
                v = v + $urandom_range(0, 32'(step_max));
            end else begin
                push_write(i, longint'($signed($urandom)));
            end
        end
    endtask

    // Aim most pitches at a threshold or one step to either side of it.
    task automatic plan_search(input int cnt);
        longint p;
        int r, off;
        r   = $urandom_range(0, 9);
        off = $urandom_range(0, 2);
        if (r < 7)       p = thr_planned[$urandom_range(0, cnt - 1)] + off - 1;
        else if (r < 9)  p = $signed($urandom);
        else             p = off[0] ? Q_MAX : Q_MIN;
        if (p < Q_MIN) p = Q_MIN;
        if (p > Q_MAX) p = Q_MAX;
        push_search(p);
    endtask

    // Wait until every beat is out and every bin is back, then let writes settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (beats_to_send.size() != 0 || bins_due.size() != 0 || s_valid);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_length(input int len);
        @(posedge aclk);
        cfg_valid        <= 1'b1;
        cfg_table_length <= qbbs_pkg::LEN_W'(len);
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        len_shadow = qbbs_pkg::LEN_W'(len);
        @(negedge aclk);
    endtask

    initial begin
        int lens [11] = '{128, 1, 0, 255, 2, 3, 129, 64, 17, 100, 85};
        int ph, cnt, i;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill every entry first so no search ever reads an unwritten slot.
        // Spread the table from the most negative code upward.
        for (i = 0; i < qbbs_pkg::MAX_ENTRIES; i++)
            push_write(i, Q_MIN + longint'(i) * 33554432 +
                          (i == 0 ? 0 : $urandom_range(0, 16777215)));

        // Directed: reset length, top entry at full scale, pitch extremes,
        // exact hits and near misses, then a pitch below entry zero and one exactly on it.
        push_write(qbbs_pkg::MAX_ENTRIES - 1, Q_MAX);
        push_search(Q_MIN);
        push_search(Q_MAX);
        push_search(0);
        push_search(-1);
        push_search(thr_planned[84]);
        push_search(longint'(thr_planned[84]) - 1);
        push_search(longint'(thr_planned[1]) - 1);
        push_search(thr_planned[1]);
        push_search(thr_planned[42]);
        push_search(longint'(thr_planned[43]) - 1);
        push_write(0, Q_MIN + 5);
        push_search(Q_MIN);
        push_search(Q_MIN + 5);
        wait_drained();

        // Random phases: new length, fresh table, then searches with a
        // sprinkle of stray writes that can break the ordering.
        for (ph = 0; ph < 11; ph++) begin
            idle_mode = ph % 4;
            write_length(lens[ph]);
            cnt = used_entries(lens[ph]);
            load_table(cnt, (ph % 3) != 2);
            repeat (60) begin
                if (roll(5))
                    push_write($urandom_range(0, qbbs_pkg::MAX_ENTRIES - 1),
                               $signed($urandom));
                else
                    plan_search(cnt);
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== quantizer_bin_binary_search_core.f =====
hdl/qbbs_pkg.sv
hdl/quantizer_bin_binary_search_core.sv
bench/quantizer_bin_binary_search_core_tb.sv
